// ===== hdl/urla_pkg.sv =====
`timescale 1ns / 1ps

package urla_pkg;

	localparam int RX_RING_DEPTH_DEF = 32;

	localparam logic [7:0] LINE_CAP_RESET = 8'd64;
	localparam logic [7:0] CHAR_CR        = 8'h0D;
	localparam logic [7:0] CHAR_LF        = 8'h0A;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [1:0] {
		KIND_CHAR    = 2'd0,
		KIND_NO_LINE = 2'd1,
		KIND_READY   = 2'd2,
		KIND_FAULT   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_OUT_CHAR,
		ST_OUT_LAST
	} state_t;

endpackage

// ===== hdl/urla_ram.sv =====
`timescale 1ns / 1ps

module urla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/uart_rx_ring_line_assembler.sv =====
`timescale 1ns / 1ps

// Receive ring buffer with a line assembler on its read side. A byte event
// (cmd 0) is taken while idle and gives no word on the output: a byte with
// rx_error set, or a byte that finds the ring full, is dropped and sets a
// sticky fault; any other byte is written to the ring, which holds up to
// RX_RING_DEPTH - 1 bytes. A read request (cmd 1) drains the ring one byte
// at a time through a registered memory read. Each stored character goes
// out as a "char stored" word with its position in the line; CR and an LF
// on an empty line are consumed silently. The request ends with one word
// marked last: line ready (LF on a non-empty line), fault (pending fault,
// line_capacity below 2, or line overflow), or no line yet (ring empty,
// partial line kept). After a read request is accepted, each stored
// character is read and decoded, then its word waits in the output register
// until taken; a byte consumed without a word (CR, LF on an empty line)
// passes straight to the next read, and the LF or overflowing byte that ends
// the request loads the final word. Output stalls hold the drain. The input
// is stalled for the whole of a read request. The line_capacity register may
// be written only while idle; cfg_ready is always high. The ring memory needs
// no clearing after reset.

module uart_rx_ring_line_assembler
	import urla_pkg::*;
#(
	parameter int RX_RING_DEPTH = RX_RING_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// input words
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] rx_byte,
	input  logic       rx_error,
	// output words
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] line_char,
	output logic [7:0] position,
	output logic [7:0] line_length,
	output logic       last,
	// line_capacity register write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int IDX_W = $clog2(RX_RING_DEPTH);

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		ring_next = (i == IDX_W'(RX_RING_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	state_t state_q, state_d;

	logic [IDX_W-1:0] wr_q, wr_d;
	logic [IDX_W-1:0] rd_q, rd_d;
	logic [7:0]       len_q, len_d;
	logic             fault_q, fault_d;
	logic [7:0]       cap_q;

	// output register
	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] char_q, pos_q, llen_q;
	logic       last_q;

	// emit request from the datapath decode
	logic       emit;
	kind_t      emit_kind;
	logic [7:0] emit_char, emit_pos, emit_len;
	logic       emit_last;

	logic             we;
	logic [IDX_W-1:0] raddr;
	logic [7:0]       rdata;

	logic             in_acc, out_take;
	logic [IDX_W-1:0] rd_inc;
	logic             ring_empty, ring_full, rd_fault;
	logic             byte_skip, byte_end, byte_ovf;

	assign in_acc     = in_valid & ~in_stall;
	assign out_take   = out_valid_q & ~out_stall;
	assign rd_inc     = ring_next(rd_q);
	assign ring_empty = (rd_q == wr_q);
	assign ring_full  = (ring_next(wr_q) == rd_q);
	assign rd_fault   = fault_q | (cap_q < 8'd2);

	// byte just read from the ring (valid in ST_READ)
	assign byte_skip = (rdata == CHAR_CR) || ((rdata == CHAR_LF) && (len_q == 8'd0));
	assign byte_end  = (rdata == CHAR_LF) && (len_q != 8'd0);
	// cap >= 2 here, so cap - 1 does not wrap
	assign byte_ovf  = (len_q >= (cap_q - 8'd1));

	// next read address: the advanced pointer while draining back to back
	assign raddr = (state_q == ST_READ) ? rd_inc : rd_q;

	urla_ram #(
		.WIDTH (8),
		.DEPTH (RX_RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (wr_q),
		.wdata (rx_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (cmd == CMD_READ)) begin
					state_d = (rd_fault || ring_empty) ? ST_OUT_LAST : ST_READ;
				end
			end
			ST_READ: begin
				if (byte_skip) begin
					state_d = (rd_inc == wr_q) ? ST_OUT_LAST : ST_READ;
				end else if (byte_end || byte_ovf) begin
					state_d = ST_OUT_LAST;
				end else begin
					state_d = ST_OUT_CHAR;
				end
			end
			ST_OUT_CHAR: begin
				if (out_take) begin
					state_d = ring_empty ? ST_OUT_LAST : ST_READ;
				end
			end
			ST_OUT_LAST: begin
				if (out_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath actions
	always_comb begin
		wr_d      = wr_q;
		rd_d      = rd_q;
		len_d     = len_q;
		fault_d   = fault_q;
		we        = 1'b0;
		emit      = 1'b0;
		emit_kind = KIND_CHAR;
		emit_char = 8'd0;
		emit_pos  = 8'd0;
		emit_len  = 8'd0;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_BYTE) begin
						if (rx_error || ring_full) begin
							fault_d = 1'b1;
						end else begin
							we   = 1'b1;
							wr_d = ring_next(wr_q);
						end
					end else if (rd_fault) begin
						len_d     = 8'd0;
						fault_d   = 1'b0;
						emit      = 1'b1;
						emit_kind = KIND_FAULT;
						emit_last = 1'b1;
					end else if (ring_empty) begin
						emit      = 1'b1;
						emit_kind = KIND_NO_LINE;
						emit_last = 1'b1;
					end
				end
			end
			ST_READ: begin
				rd_d = rd_inc;
				if (byte_skip) begin
					if (rd_inc == wr_q) begin
						emit      = 1'b1;
						emit_kind = KIND_NO_LINE;
						emit_last = 1'b1;
					end
				end else if (byte_end) begin
					emit      = 1'b1;
					emit_kind = KIND_READY;
					emit_len  = len_q;
					emit_last = 1'b1;
					len_d     = 8'd0;
				end else if (byte_ovf) begin
					emit      = 1'b1;
					emit_kind = KIND_FAULT;
					emit_last = 1'b1;
					len_d     = 8'd0;
				end else begin
					emit      = 1'b1;
					emit_kind = KIND_CHAR;
					emit_char = rdata;
					emit_pos  = len_q;
					len_d     = len_q + 8'd1;
				end
			end
			ST_OUT_CHAR: begin
				if (out_take && ring_empty) begin
					emit      = 1'b1;
					emit_kind = KIND_NO_LINE;
					emit_last = 1'b1;
				end
			end
			ST_OUT_LAST: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wr_q        <= '0;
			rd_q        <= '0;
			len_q       <= 8'd0;
			fault_q     <= 1'b0;
			cap_q       <= LINE_CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wr_q    <= wr_d;
			rd_q    <= rd_d;
			len_q   <= len_d;
			fault_q <= fault_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload, loaded only when a new word is made
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= emit_kind;
			char_q <= emit_char;
			pos_q  <= emit_pos;
			llen_q <= emit_len;
			last_q <= emit_last;
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign line_char   = char_q;
	assign position    = pos_q;
	assign line_length = llen_q;
	assign last        = last_q;

endmodule
